>>> src/cpr_pkg.sv
package cpr_pkg;

    localparam int TableEntries = 256;
    localparam int IdxW = $clog2(TableEntries);
    localparam int CntW = IdxW + 1;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_ACCESS = 2'd1;
    localparam logic [1:0] ACT_DIRTY  = 2'd2;
    localparam logic [1:0] ACT_EVICT  = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOVICTIM = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture request fields
        logic       ins;       // write new entry at count
        logic       rd;        // read entry (addr chosen by rd_last and sel_hand)
        logic       sel_hand;  // read address is hand, else scan index
        logic       scan_clr;  // clear scan index and counter
        logic       scan_inc;  // advance lookup scan index
        logic       set_bit;   // set accessed or dirty at scan index
        logic       clr_acc;   // clear accessed bit at hand
        logic       hand_inc;  // advance hand with wrap
        logic       rd_last;   // read last entry
        logic       mv_last;   // write last entry into hand slot
        logic       take_vic;  // latch victim fields from read data
        logic       result;    // present result
        logic [1:0] status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       empty;
        logic       scan_end;  // lookup index is at the last entry
        logic       match;     // read entry matches request
        logic       user_page; // read entry below kernel base
        logic       acc;       // read entry accessed bit
        logic       limit;     // evict visited twice count
        logic       out_busy;  // result register still held
    } t_sts;

endpackage

>>> src/clock_page_replacement_unit.sv
// channel   direction  tdata fields (low bit up)                 handshake
// s_axis    in         action[1:0], page_address, owner_id, pad  tvalid/tready
// m_axis    out        status[1:0], victim_address, victim_owner,
//                      victim_dirty, pad                         tvalid/tready
// cfg       in         kbase (kernel page limit)                 i_cfg_we
// one request at a time; access/mark dirty compare entries one by one,
// evict steps the hand one entry at a time and reports no victim after
// twice the entry count of steps; all use the single table read port
// reset clears count, hand, kernel limit (0xC0000000) and the result register
// the result waits in an output register while the downstream side stalls
module clock_page_replacement_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,        // kbase
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,      // action, page_address, owner_id
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata       // status, victim_address, victim_owner, victim_dirty
);
    import cpr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cpr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req       (s_axis_tdata[49:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_take  (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

>>> src/cpr_datapath.sv
module cpr_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_data,
    input  logic [49:0]    i_req,
    input  cpr_pkg::t_cmd  i_cmd,
    output cpr_pkg::t_sts  o_sts,
    input  logic           i_out_take,
    output logic           o_out_valid,
    output logic [55:0]    o_out_data
);
    import cpr_pkg::*;

    logic [31:0]   mem_addr [TableEntries];
    logic [15:0]   mem_own  [TableEntries];
    logic [TableEntries-1:0] r_acc, r_dirty;

    logic [31:0]   r_kbase;
    logic [1:0]    r_act;
    logic [31:0]   r_paddr;
    logic [15:0]   r_powner;
    logic [CntW-1:0] r_count;
    logic [IdxW-1:0] r_hand, r_idx;
    logic [CntW:0]   r_scanned;
    logic [31:0]   r_rd_addr;
    logic [15:0]   r_rd_own;
    logic          r_rd_acc, r_rd_dirty;
    logic          r_ovalid;
    logic [55:0]   r_odata;
    logic [31:0]   r_vaddr;
    logic [15:0]   r_vown;
    logic          r_vdirty;

    logic [IdxW-1:0] rd_idx, last_idx, wr_idx, n_hand;
    logic [CntW-1:0] hand_ext;

    assign last_idx = IdxW'(r_count - CntW'(1));
    assign rd_idx   = i_cmd.rd_last ? last_idx : (i_cmd.sel_hand ? r_hand : r_idx);
    assign wr_idx   = i_cmd.ins ? r_count[IdxW-1:0] : r_hand;
    assign hand_ext = CntW'(r_hand) + CntW'(1);
    assign n_hand   = (hand_ext >= r_count) ? '0 : hand_ext[IdxW-1:0];

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins || i_cmd.mv_last) begin
            mem_addr[wr_idx] <= i_cmd.ins ? r_paddr : r_rd_addr;
            mem_own[wr_idx]  <= i_cmd.ins ? r_powner : r_rd_own;
        end
        if (i_cmd.rd) begin
            r_rd_addr <= mem_addr[rd_idx];
            r_rd_own  <= mem_own[rd_idx];
            r_rd_acc  <= r_acc[rd_idx];
            r_rd_dirty <= r_dirty[rd_idx];
        end
    end

    // flag bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            r_acc[wr_idx]   <= 1'b0;
            r_dirty[wr_idx] <= 1'b0;
        end
        if (i_cmd.mv_last) begin
            r_acc[r_hand]   <= r_rd_acc;
            r_dirty[r_hand] <= r_rd_dirty;
        end
        if (i_cmd.set_bit) begin
            if (r_act == ACT_ACCESS) r_acc[r_idx] <= 1'b1;
            else r_dirty[r_idx] <= 1'b1;
        end
        if (i_cmd.clr_acc) r_acc[r_hand] <= 1'b0;
    end

    // request capture and victim latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= i_req[1:0];
            r_paddr  <= i_req[33:2];
            r_powner <= i_req[49:34];
        end
        if (i_cmd.take_vic) begin
            r_vaddr  <= r_rd_addr;
            r_vown   <= r_rd_own;
            r_vdirty <= r_rd_dirty;
        end
    end

    // control state: config, count, hand, scan index, result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbase   <= 32'hC000_0000;
            r_count   <= '0;
            r_hand    <= '0;
            r_idx     <= '0;
            r_scanned <= '0;
            r_ovalid  <= 1'b0;
            r_odata   <= '0;
        end else begin
            if (i_cfg_we) r_kbase <= i_cfg_data;
            if (i_cmd.ins) r_count <= r_count + CntW'(1);
            if (i_cmd.mv_last) begin
                r_count <= r_count - CntW'(1);
                if (CntW'(r_hand) >= r_count - CntW'(1)) r_hand <= '0;
            end
            if (i_cmd.scan_clr) begin
                r_idx     <= '0;
                r_scanned <= '0;
                if (CntW'(r_hand) >= r_count) r_hand <= '0;
            end
            if (i_cmd.scan_inc) r_idx <= r_idx + IdxW'(1);
            if (i_cmd.hand_inc) begin
                r_hand    <= n_hand;
                r_scanned <= r_scanned + (CntW+1)'(1);
            end
            if (i_cmd.result) begin
                r_ovalid <= 1'b1;
                if (i_cmd.status == ST_DONE && r_act == ACT_EVICT)
                    r_odata <= {5'd0, r_vdirty, r_vown, r_vaddr, i_cmd.status};
                else
                    r_odata <= {54'd0, i_cmd.status};
            end else if (i_out_take) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.action    = r_act;
    assign o_sts.full      = (r_count == CntW'(TableEntries));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.scan_end  = ((CntW'(r_idx) + CntW'(1)) >= r_count);
    assign o_sts.match     = (r_rd_addr == r_paddr) && (r_rd_own == r_powner);
    assign o_sts.user_page = (r_rd_addr < r_kbase);
    assign o_sts.acc       = r_rd_acc;
    assign o_sts.limit     = (r_scanned >= {r_count, 1'b0});
    assign o_sts.out_busy  = r_ovalid;
    assign o_out_valid     = r_ovalid;
    assign o_out_data      = r_odata;

    // count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(TableEntries)) else $error("entry count overflow");
    // hand stays inside the table once a scan starts
    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_acc |-> (CntW'(r_hand) < r_count)) else $error("hand out of range");
    // insert never happens on a full table
    a_ins_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins |-> !o_sts.full) else $error("insert into full table");

endmodule

>>> src/cpr_ctrl.sv
module cpr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cpr_pkg::t_sts i_sts,
    output cpr_pkg::t_cmd o_cmd
);
    import cpr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_LREAD = 3'd2;
    localparam logic [2:0] S_LCHK  = 3'd3;
    localparam logic [2:0] S_EREAD = 3'd4;
    localparam logic [2:0] S_ECHK  = 3'd5;
    localparam logic [2:0] S_MOVE  = 3'd6;
    localparam logic [2:0] S_RES   = 3'd7;

    logic [2:0] r_state, n_state;
    logic [1:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    // sequencing of one request
    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.scan_clr = 1'b1;
                n_status = ST_DONE;
                case (i_sts.action)
                    ACT_INSERT: begin
                        if (i_sts.full) n_status = ST_FULL;
                        else o_cmd.ins = 1'b1;
                        n_state = S_RES;
                    end
                    ACT_ACCESS, ACT_DIRTY: begin
                        if (i_sts.empty) begin
                            n_status = ST_NOTFOUND;
                            n_state = S_RES;
                        end else n_state = S_LREAD;
                    end
                    default: begin
                        if (i_sts.empty) begin
                            n_status = ST_NOVICTIM;
                            n_state = S_RES;
                        end else n_state = S_EREAD;
                    end
                endcase
            end
            S_LREAD: begin
                o_cmd.rd = 1'b1;
                n_state = S_LCHK;
            end
            S_LCHK: begin
                if (i_sts.match) begin
                    o_cmd.set_bit = 1'b1;
                    n_state = S_RES;
                end else if (i_sts.scan_end) begin
                    n_status = ST_NOTFOUND;
                    n_state = S_RES;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state = S_LREAD;
                end
            end
            S_EREAD: begin
                if (i_sts.limit) begin
                    n_status = ST_NOVICTIM;
                    n_state = S_RES;
                end else begin
                    o_cmd.rd = 1'b1;
                    o_cmd.sel_hand = 1'b1;
                    n_state = S_ECHK;
                end
            end
            S_ECHK: begin
                if (i_sts.user_page && !i_sts.acc) begin
                    o_cmd.take_vic = 1'b1;
                    o_cmd.rd = 1'b1;
                    o_cmd.rd_last = 1'b1;
                    n_state = S_MOVE;
                end else begin
                    if (i_sts.user_page) o_cmd.clr_acc = 1'b1;
                    o_cmd.hand_inc = 1'b1;
                    n_state = S_EREAD;
                end
            end
            S_MOVE: begin
                o_cmd.mv_last = 1'b1;
                n_state = S_RES;
            end
            S_RES: begin
                if (!i_sts.out_busy) begin
                    o_cmd.result = 1'b1;
                    o_cmd.status = r_status;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a result is issued only from the result state
    a_res_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result |-> r_state == S_RES) else $error("result outside result state");
    // victim move always follows a victim read
    a_move_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mv_last |-> $past(o_cmd.take_vic)) else $error("move without victim");
    // input taken only when idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready while busy");

endmodule
